[rtl/core/mcmp_pkg.sv]
// Shared types and constants for the MIDI channel message parser.
package mcmp_pkg;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 4;
    localparam int CHAN_W    = 4;
    localparam int KIND_W    = 3;
    localparam int DATA_W    = 7;

    localparam logic [KIND_W-1:0] KIND_NOTE_OFF   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PROGRAM    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONTROL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PITCH      = 3'd4;

    localparam logic [7:0] RT_TIMING_CLOCK = 8'hF8;
    localparam logic [7:0] RT_START        = 8'hFA;
    localparam logic [7:0] RT_STOP         = 8'hFC;

    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CONTROL  = 4'hB;
    localparam logic [3:0] STAT_PROGRAM  = 4'hC;
    localparam logic [3:0] STAT_PITCH    = 4'hE;
    localparam logic [3:0] STAT_SYSTEM   = 4'hF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } msg_t;

    typedef struct packed {
        logic valid;
        msg_t msg;
    } push_t;

endpackage

[rtl/core/mcmp_parser.sv]
// Running-status byte parser that emits complete channel voice messages.
module mcmp_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       byte_en,
    input  logic [7:0]                 rx_byte,
    input  logic [mcmp_pkg::CHAN_W-1:0] listen_channel,
    output mcmp_pkg::push_t            push
);
    import mcmp_pkg::*;

    localparam logic [3:0] PH_IGNORE = 4'd0;
    localparam logic [3:0] PH_NON_A  = 4'd1;
    localparam logic [3:0] PH_NON_B  = 4'd2;
    localparam logic [3:0] PH_NOFF_A = 4'd3;
    localparam logic [3:0] PH_NOFF_B = 4'd4;
    localparam logic [3:0] PH_PROG   = 4'd5;
    localparam logic [3:0] PH_CC_A   = 4'd6;
    localparam logic [3:0] PH_CC_B   = 4'd7;
    localparam logic [3:0] PH_PW_A   = 4'd8;
    localparam logic [3:0] PH_PW_B   = 4'd9;

    logic [3:0]        phase_reg;
    logic [3:0]        phase_next;
    logic [DATA_W-1:0] held_reg;
    logic [DATA_W-1:0] held_next;
    logic [DATA_W-1:0] data_byte;

    assign data_byte = rx_byte[DATA_W-1:0];

    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        push        = '0;
        push.msg.first  = held_reg;
        push.msg.second = data_byte;
        if (byte_en) begin
            if (rx_byte[7]) begin
                if (rx_byte == RT_TIMING_CLOCK || rx_byte == RT_START || rx_byte == RT_STOP) begin
                    phase_next = phase_reg;
                end else if (rx_byte[7:4] != STAT_SYSTEM && rx_byte[3:0] == listen_channel) begin
                    unique case (rx_byte[7:4])
                        STAT_NOTE_ON:  phase_next = PH_NON_A;
                        STAT_NOTE_OFF: phase_next = PH_NOFF_A;
                        STAT_PROGRAM:  phase_next = PH_PROG;
                        STAT_PITCH:    phase_next = PH_PW_A;
                        STAT_CONTROL:  phase_next = PH_CC_A;
                        default:       phase_next = PH_IGNORE;
                    endcase
                end else begin
                    phase_next = PH_IGNORE;
                end
            end else begin
                unique case (phase_reg) inside
                    PH_NON_A, PH_NOFF_A, PH_CC_A, PH_PW_A: begin
                        held_next  = data_byte;
                        phase_next = phase_reg + 4'd1;
                    end
                    PH_NON_B: begin
                        push.valid    = 1'b1;
                        push.msg.kind = (data_byte == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
                        phase_next    = PH_NON_A;
                    end
                    PH_NOFF_B: begin
                        push.valid    = 1'b1;
                        push.msg.kind = KIND_NOTE_OFF;
                        phase_next    = PH_NOFF_A;
                    end
                    PH_CC_B: begin
                        push.valid    = 1'b1;
                        push.msg.kind = KIND_CONTROL;
                        phase_next    = PH_CC_A;
                    end
                    PH_PW_B: begin
                        push.valid    = 1'b1;
                        push.msg.kind = KIND_PITCH;
                        phase_next    = PH_PW_A;
                    end
                    PH_PROG: begin
                        push.valid      = 1'b1;
                        push.msg.kind   = KIND_PROGRAM;
                        push.msg.first  = data_byte;
                        push.msg.second = '0;
                    end
                    default: phase_next = PH_IGNORE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IGNORE;
            held_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[rtl/core/mcmp_queue.sv]
// Ring FIFO of parsed messages with a registered read port and drop on full.
module mcmp_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  mcmp_pkg::push_t push,
    input  logic            pop,
    output logic            pop_hit,
    output mcmp_pkg::msg_t  rd_msg
);
    import mcmp_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    msg_t          mem [QUEUE_DEPTH];
    msg_t          rd_msg_reg;
    logic [AW-1:0] wr_slot_reg;
    logic [AW-1:0] wr_slot_next;
    logic [AW-1:0] rd_slot_reg;
    logic [AW-1:0] rd_slot_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push_ok;

    assign push_ok = push.valid && (count_reg != CW'(QUEUE_DEPTH));
    assign pop_hit = pop && (count_reg != '0);
    assign rd_msg  = rd_msg_reg;

    always_comb begin
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        count_next   = count_reg;
        if (push_ok) begin
            wr_slot_next = (wr_slot_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_slot_reg + 1'b1;
            count_next   = count_reg + 1'b1;
        end else if (pop_hit) begin
            rd_slot_next = (rd_slot_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_slot_reg + 1'b1;
            count_next   = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_slot_reg <= '0;
            rd_slot_reg <= '0;
            count_reg   <= '0;
        end else begin
            wr_slot_reg <= wr_slot_next;
            rd_slot_reg <= rd_slot_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_slot_reg] <= push.msg;
        end
        if (pop_hit) begin
            rd_msg_reg <= mem[rd_slot_reg];
        end
    end

endmodule

[rtl/core/midi_channel_message_parser_core.sv]
// Top level of the MIDI channel message parser with its message queue.
//
//  Channel  Direction  Signals                       Contents
//  s_       in         s_tvalid s_tready s_tdata     rx_byte; s_tuser = func
//  m_       out        m_tvalid m_tready m_tdata     data_first, data_second;
//                                                    m_tuser = msg_valid, msg_kind
//  cfg_     in         cfg_valid cfg_ready cfg_data  listen_channel
//
// One beat is taken per cycle while s_tready is high; a fetch shows its result in the cycle after acceptance.
// The single output register sets the rate: input stalls only while it holds an
// untaken result and m_tready is low.
// Reset is synchronous and active low; it empties the queue and sets the parser to
// ignore until the next status byte. Configuration is always ready.
module midi_channel_message_parser_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mcmp_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic                                s_tuser,   // [0] func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mcmp_pkg::M_TDATA_W-1:0]      m_tdata,   // [6:0] data_first, [13:7] data_second, [15:14] zero
    output logic [mcmp_pkg::M_TUSER_W-1:0]      m_tuser,   // [0] msg_valid, [3:1] msg_kind
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mcmp_pkg::CHAN_W-1:0]         cfg_data   // [3:0] listen_channel
);
    import mcmp_pkg::*;

    logic [CHAN_W-1:0] channel_reg;
    logic              m_tvalid_reg;
    logic              hit_reg;
    logic              s_beat;
    logic              fetch;
    logic              pop_hit;
    push_t             push;
    msg_t              rd_msg;
    msg_t              out_msg;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_beat    = s_tvalid && s_tready;
    assign fetch     = s_beat && s_tuser;
    assign cfg_ready = 1'b1;

    mcmp_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_en        (s_beat && !s_tuser),
        .rx_byte        (s_tdata),
        .listen_channel (channel_reg),
        .push           (push)
    );

    mcmp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (fetch),
        .pop_hit (pop_hit),
        .rd_msg  (rd_msg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                channel_reg <= cfg_data;
            end
            if (fetch) begin
                m_tvalid_reg <= 1'b1;
                hit_reg      <= pop_hit;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign out_msg  = hit_reg ? rd_msg : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_msg.kind, hit_reg};
    assign m_tdata  = {2'b00, out_msg.second, out_msg.first};

endmodule

[rtl/core/mcmp_checker.sv]
// Port-level checks for the MIDI channel message parser, bound to the top level.
module mcmp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mcmp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mcmp_pkg::M_TUSER_W-1:0] m_tuser
);
    import mcmp_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0 && m_tuser[3:1] == '0)
        else $error("Empty fetch result carries nonzero fields.");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[3:1] <= KIND_PITCH && m_tdata[15:14] == 2'b00)
        else $error("Result beat holds an illegal kind or padding.");

    a_fetch_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> m_tvalid)
        else $error("Fetch beat produced no result.");

    a_parse_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("Parsed byte produced a result beat.");

endmodule

bind midi_channel_message_parser_core mcmp_checker u_mcmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[sim/midi_channel_message_parser_core_test.sv]
// Self-checking testbench for the MIDI channel message parser core and its queue.
module midi_channel_message_parser_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcmp_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic FUNC_PARSE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;
    localparam logic [3:0] STAT_POLY_PRESSURE = 4'hA;

    typedef enum logic [3:0] {
        WAIT_STATUS, NOTE_ON_KEY, NOTE_ON_VEL, NOTE_OFF_KEY, NOTE_OFF_VEL,
        PROGRAM_NUM, CONTROL_NUM, CONTROL_VAL, PITCH_LSB, PITCH_MSB
    } parse_phase_e;

    typedef struct packed {
        logic valid;
        msg_t msg;
    } fetch_result_t;

    class MidiQueueScoreboard;
        logic [CHAN_W-1:0] channel;
        parse_phase_e phase;
        logic [DATA_W-1:0] held;
        msg_t store [QUEUE_DEPTH];
        int unsigned wr_slot;
        int unsigned rd_slot;
        int unsigned count;
        fetch_result_t expected_fetches [$];
        int unsigned mismatches;

        function new();
            channel = '0;
            phase = WAIT_STATUS;
            held = '0;
            wr_slot = 0;
            rd_slot = 0;
            count = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_fetches.size();
        endfunction

        function void queue_message(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] first,
                                    logic [DATA_W-1:0] second);
            if (count >= QUEUE_DEPTH)
                return;
            store[wr_slot] = '{kind: kind, first: first, second: second};
            wr_slot = (wr_slot + 1) % QUEUE_DEPTH;
            count++;
        endfunction

        function void note_beat(logic func, logic [7:0] b);
            fetch_result_t res;
            if (func == FUNC_FETCH) begin
                res = '0;
                if (count != 0) begin
                    res.valid = 1'b1;
                    res.msg = store[rd_slot];
                    rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
                    count--;
                end
                expected_fetches.push_back(res);
                return;
            end
            if (b[7]) begin
                if (b == RT_TIMING_CLOCK || b == RT_START || b == RT_STOP)
                    return;
                phase = WAIT_STATUS;
                if (b[7:4] != STAT_SYSTEM && b[3:0] == channel) begin
                    case (b[7:4])
                        STAT_NOTE_ON:  phase = NOTE_ON_KEY;
                        STAT_NOTE_OFF: phase = NOTE_OFF_KEY;
                        STAT_PROGRAM:  phase = PROGRAM_NUM;
                        STAT_PITCH:    phase = PITCH_LSB;
                        STAT_CONTROL:  phase = CONTROL_NUM;
                        default:       phase = WAIT_STATUS;
                    endcase
                end
                return;
            end
            case (phase)
                NOTE_ON_KEY: begin
                    held = b[6:0];
                    phase = NOTE_ON_VEL;
                end
                NOTE_ON_VEL: begin
                    queue_message((b[6:0] == '0) ? KIND_NOTE_OFF : KIND_NOTE_ON, held, b[6:0]);
                    phase = NOTE_ON_KEY;
                end
                NOTE_OFF_KEY: begin
                    held = b[6:0];
                    phase = NOTE_OFF_VEL;
                end
                NOTE_OFF_VEL: begin
                    queue_message(KIND_NOTE_OFF, held, b[6:0]);
                    phase = NOTE_OFF_KEY;
                end
                PROGRAM_NUM: queue_message(KIND_PROGRAM, b[6:0], '0);
                CONTROL_NUM: begin
                    held = b[6:0];
                    phase = CONTROL_VAL;
                end
                CONTROL_VAL: begin
                    queue_message(KIND_CONTROL, held, b[6:0]);
                    phase = CONTROL_NUM;
                end
                PITCH_LSB: begin
                    held = b[6:0];
                    phase = PITCH_MSB;
                end
                PITCH_MSB: begin
                    queue_message(KIND_PITCH, held, b[6:0]);
                    phase = PITCH_LSB;
                end
                default: phase = WAIT_STATUS;
            endcase
        endfunction

        function void check_result(logic [M_TUSER_W-1:0] tuser, logic [M_TDATA_W-1:0] tdata);
            fetch_result_t want;
            fetch_result_t got;
            got.valid = tuser[0];
            got.msg.kind = tuser[3:1];
            got.msg.first = tdata[6:0];
            got.msg.second = tdata[13:7];
            if (expected_fetches.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result with nothing outstanding: valid %0b kind %0d %0d %0d",
                             $realtime, got.valid, got.msg.kind, got.msg.first, got.msg.second);
                mismatches++;
                return;
            end
            want = expected_fetches.pop_front();
            if (got.valid !== want.valid || got.msg.kind !== want.msg.kind
                    || got.msg.first !== want.msg.first || got.msg.second !== want.msg.second) begin
                if (mismatches < 10)
                    $display("%0t: fetch mismatch: expected valid %0b kind %0d first %0d second %0d, got valid %0b kind %0d first %0d second %0d",
                             $realtime, want.valid, want.msg.kind, want.msg.first, want.msg.second,
                             got.valid, got.msg.kind, got.msg.first, got.msg.second);
                mismatches++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CHAN_W-1:0] cfg_data = '0;

    MidiQueueScoreboard sb;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;
    logic [CHAN_W-1:0] listen_ch = '0;
    logic [7:0] last_status = '0;

    midi_channel_message_parser_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always begin
        #5ns aclk = 1'b1;
        #5ns aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL midi_channel_message_parser_core");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.channel = cfg_data;
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata);
        end
    end

    task automatic send_beat(input logic func, input logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_channel(input logic [CHAN_W-1:0] ch);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data <= ch;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        listen_ch = ch;
        last_status = '0;
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge aclk);
        rx_hold <= 1'b0;
    endtask

    function automatic logic [7:0] data_value();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h7F;
            default: return {1'b0, 7'($urandom_range(0, 127))};
        endcase
    endfunction

    function automatic logic [3:0] pick_voice();
        case ($urandom_range(0, 4))
            0: return STAT_NOTE_ON;
            1: return STAT_NOTE_OFF;
            2: return STAT_PROGRAM;
            3: return STAT_CONTROL;
            default: return STAT_PITCH;
        endcase
    endfunction

    function automatic logic [7:0] pick_realtime();
        case ($urandom_range(0, 2))
            0: return RT_TIMING_CLOCK;
            1: return RT_START;
            default: return RT_STOP;
        endcase
    endfunction

    task automatic send_message();
        logic [3:0] voice;
        logic [3:0] ch;
        logic [7:0] status;
        int n_data;
        voice = pick_voice();
        ch = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : listen_ch;
        status = {voice, ch};
        if (status != last_status || $urandom_range(0, 2) != 0)
            send_beat(FUNC_PARSE, status);
        last_status = status;
        n_data = (voice == STAT_PROGRAM) ? 1 : 2;
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(FUNC_PARSE, pick_realtime());
            send_beat(FUNC_PARSE, data_value());
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_beat(FUNC_PARSE, 8'($urandom_range(0, 255)));
            1: begin
                send_beat(FUNC_PARSE, {pick_voice(), listen_ch});
                send_beat(FUNC_PARSE, data_value());
            end
            2: begin
                send_beat(FUNC_PARSE, {STAT_POLY_PRESSURE, listen_ch});
                send_beat(FUNC_PARSE, data_value());
                send_beat(FUNC_PARSE, data_value());
            end
            default: send_beat(FUNC_PARSE, {STAT_SYSTEM, 4'($urandom_range(0, 15))});
        endcase
        last_status = '0;
    endtask

    task automatic random_traffic(input int n, input int fetch_pct);
        int unsigned target;
        int r;
        target = items_sent + n;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < fetch_pct)
                send_beat(FUNC_FETCH, 8'($urandom_range(0, 255)));
            else if (r < fetch_pct + (100 - fetch_pct) * 4 / 5)
                send_message();
            else
                send_noise();
        end
    endtask

    task automatic run_intro();
        logic [8:0] steps [$] = '{
            {FUNC_FETCH, 8'hFF},
            {FUNC_PARSE, 8'h40},
            {FUNC_PARSE, STAT_NOTE_ON, 4'h0}, {FUNC_PARSE, 8'h3C}, {FUNC_PARSE, 8'h7F},
            {FUNC_PARSE, 8'h00}, {FUNC_PARSE, 8'h00},
            {FUNC_PARSE, RT_TIMING_CLOCK}, {FUNC_PARSE, 8'h7F}, {FUNC_PARSE, RT_START},
            {FUNC_PARSE, 8'h40}, {FUNC_PARSE, RT_STOP},
            {FUNC_PARSE, STAT_NOTE_OFF, 4'h0}, {FUNC_PARSE, 8'h7F}, {FUNC_PARSE, 8'h7F},
            {FUNC_PARSE, STAT_PROGRAM, 4'h0}, {FUNC_PARSE, 8'h05},
            {FUNC_PARSE, STAT_CONTROL, 4'h0}, {FUNC_PARSE, 8'h07}, {FUNC_PARSE, 8'h64},
            {FUNC_PARSE, STAT_PITCH, 4'h0}, {FUNC_PARSE, 8'h00}, {FUNC_PARSE, 8'h7F},
            {FUNC_PARSE, STAT_POLY_PRESSURE, 4'h0}, {FUNC_PARSE, 8'h10},
            {FUNC_FETCH, 8'h00}
        };
        foreach (steps[i])
            send_beat(steps[i][8], steps[i][7:0]);
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_channel(4'd0);
        run_intro();
        random_traffic(90, 30);

        write_channel(4'd15);
        random_traffic(60, 3);
        random_traffic(30, 70);
        tx_idle_pct = 60;
        random_traffic(60, 30);

        write_channel(4'd9);
        tx_idle_pct = 0;
        rx_stall_pct = 60;
        random_traffic(60, 35);

        write_channel(4'($urandom_range(0, 15)));
        tx_idle_pct = 23;
        rx_stall_pct = 23;
        random_traffic(60, 30);

        write_channel(4'd0);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        fork
            hold_receiver(300);
            random_traffic(50, 25);
        join
        random_traffic(20, 60);

        wait_until_drained();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS midi_channel_message_parser_core");
        else
            $display("FAIL midi_channel_message_parser_core");
        $finish;
    end

endmodule
